@@ design/software_timer_bank_macros.svh @@
// assertion helpers for the timer bank sequencer
// each use expects clk and arst_n in scope
`ifndef SOFTWARE_TIMER_BANK_MACROS_SVH
`define SOFTWARE_TIMER_BANK_MACROS_SVH

// same-cycle implication
`define STB_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define STB_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/stb_pkg.sv @@
package stb_pkg;

	localparam logic [2:0] CMD_TICK       = 3'd0;
	localparam logic [2:0] CMD_REGISTER   = 3'd1;
	localparam logic [2:0] CMD_UNREGISTER = 3'd2;
	localparam logic [2:0] CMD_START      = 3'd3;
	localparam logic [2:0] CMD_STOP       = 3'd4;
	localparam logic [2:0] CMD_SET_TIME   = 3'd5;
	localparam logic [2:0] CMD_RESTART    = 3'd6;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
	localparam logic [1:0] STATUS_FULL      = 2'd2;

	// dividend is 2*d + tb, divisor is 2*tb
	localparam int DIV_NUM_W = 34;
	localparam int DIV_DEN_W = 33;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_RD,
		ST_EVAL,
		ST_DONE
	} seq_state_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quo;
	} div_rsp_t;

	typedef struct packed {
		logic        valid;
		logic [1:0]  status;
		logic [31:0] new_handle;
		logic        fired;
		logic [31:0] fired_handle;
	} result_t;

	typedef struct packed {
		logic [31:0] handle;
		logic [31:0] count;
		logic [31:0] reload;
		logic        periodic;
	} slot_t;

endpackage

@@ design/stb_div.sv @@
module stb_div (
	input  logic              clk,
	input  logic              arst_n,
	input  stb_pkg::div_req_t req,
	output stb_pkg::div_rsp_t rsp
);

	localparam int NW = stb_pkg::DIV_NUM_W;
	localparam int DW = stb_pkg::DIV_DEN_W;
	localparam int CW = $clog2(NW);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] den_q;

	logic [DW:0] trial;
	logic [DW:0] diff;
	logic        ge;

	// one restoring step per cycle, msb first
	assign trial = {rem_q, quo_q[NW-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q[31:0];

endmodule

@@ design/stb_seq.sv @@
`include "software_timer_bank_macros.svh"

module stb_seq #(
	parameter int SLOTS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        cmd,
	input  logic [31:0]       handle,
	input  logic [31:0]       delay_us,
	input  logic              periodic,
	input  logic [31:0]       timebase,
	output stb_pkg::result_t  res,
	input  logic              res_take,
	output stb_pkg::div_req_t div_req,
	input  stb_pkg::div_rsp_t div_rsp
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [31:0] HANDLE_BASE = 32'h0000_EEDF;
	localparam logic [31:0] SAT_MIN     = 32'h8000_0000;

	stb_pkg::seq_state_t state_q, state_d;

	logic [2:0]       cmd_q;
	logic [31:0]      handle_q;
	logic             periodic_q;
	logic [IW-1:0]    idx_q;
	logic [31:0]      count_q;
	logic [31:0]      hcnt_q;
	logic [1:0]       status_q;
	logic [31:0]      nh_q;
	logic             fired_q;
	logic [31:0]      fh_q;
	logic [SLOTS-1:0] in_use_q;
	logic [SLOTS-1:0] run_q;

	stb_pkg::slot_t mem [SLOTS];
	stb_pkg::slot_t rd_q;

	logic           accept;
	logic           need_div;
	logic           last;
	logic           occ;
	logic           match;
	logic [31:0]    dec;
	logic [31:0]    nh_next;
	logic [31:0]    d_eff;

	logic           mem_we;
	stb_pkg::slot_t mem_wdata;
	logic           finish;
	logic [1:0]     new_status;
	logic           use_set;
	logic           use_clr;
	logic           run_set;
	logic           run_clr;
	logic           fire;
	logic           take_handle;

	assign accept   = in_valid && (state_q == stb_pkg::ST_IDLE);
	assign need_div = (cmd == stb_pkg::CMD_REGISTER) || (cmd == stb_pkg::CMD_SET_TIME);
	assign last     = idx_q == IW'(SLOTS - 1);
	assign occ      = in_use_q[idx_q];
	assign match    = occ && (rd_q.handle == handle_q);
	assign dec      = (rd_q.count == SAT_MIN) ? rd_q.count : rd_q.count - 32'd1;
	assign nh_next  = HANDLE_BASE + hcnt_q + 32'd1;
	assign d_eff    = (delay_us < timebase) ? timebase : delay_us;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			stb_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (need_div)
						state_d = stb_pkg::ST_DIV;
					else if (cmd <= stb_pkg::CMD_RESTART)
						state_d = stb_pkg::ST_RD;
					else
						state_d = stb_pkg::ST_DONE;
				end
			end
			stb_pkg::ST_DIV: begin
				if (div_rsp.done)
					state_d = stb_pkg::ST_RD;
			end
			stb_pkg::ST_RD:   state_d = stb_pkg::ST_EVAL;
			stb_pkg::ST_EVAL: state_d = finish ? stb_pkg::ST_DONE : stb_pkg::ST_RD;
			stb_pkg::ST_DONE: begin
				if (res_take)
					state_d = stb_pkg::ST_IDLE;
			end
			default: state_d = stb_pkg::ST_IDLE;
		endcase
	end

	// outputs and per-slot decisions
	always_comb begin
		mem_we      = 1'b0;
		mem_wdata   = rd_q;
		finish      = 1'b0;
		new_status  = stb_pkg::STATUS_OK;
		use_set     = 1'b0;
		use_clr     = 1'b0;
		run_set     = 1'b0;
		run_clr     = 1'b0;
		fire        = 1'b0;
		take_handle = 1'b0;

		in_stall = state_q != stb_pkg::ST_IDLE;

		div_req.start = accept && need_div;
		div_req.num   = {1'b0, d_eff, 1'b0} + {2'b00, timebase};
		div_req.den   = {timebase, 1'b0};

		res.valid        = state_q == stb_pkg::ST_DONE;
		res.status       = status_q;
		res.new_handle   = nh_q;
		res.fired        = fired_q;
		res.fired_handle = fh_q;

		if (state_q == stb_pkg::ST_EVAL) begin
			unique case (cmd_q)
				stb_pkg::CMD_TICK: begin
					finish = last;
					if (occ && run_q[idx_q]) begin
						mem_we          = 1'b1;
						mem_wdata.count = dec;
						// only the lowest expired slot fires per tick
						if (!fired_q && ((dec == 32'd0) || dec[31])) begin
							fire = 1'b1;
							if (rd_q.periodic)
								mem_wdata.count = rd_q.reload;
							else
								run_clr = 1'b1;
						end
					end
				end
				stb_pkg::CMD_REGISTER: begin
					if (!occ) begin
						mem_we             = 1'b1;
						mem_wdata.handle   = nh_next;
						mem_wdata.count    = count_q;
						mem_wdata.reload   = count_q;
						mem_wdata.periodic = periodic_q;
						use_set            = 1'b1;
						run_clr            = 1'b1;
						take_handle        = 1'b1;
						finish             = 1'b1;
					end else if (last) begin
						finish     = 1'b1;
						new_status = stb_pkg::STATUS_FULL;
					end
				end
				stb_pkg::CMD_UNREGISTER, stb_pkg::CMD_START, stb_pkg::CMD_STOP,
				stb_pkg::CMD_SET_TIME, stb_pkg::CMD_RESTART: begin
					if (match) begin
						finish = 1'b1;
						unique case (cmd_q)
							stb_pkg::CMD_UNREGISTER: begin
								use_clr = 1'b1;
								run_clr = 1'b1;
							end
							stb_pkg::CMD_START, stb_pkg::CMD_RESTART: begin
								mem_we          = 1'b1;
								mem_wdata.count = rd_q.reload;
								run_set         = 1'b1;
							end
							stb_pkg::CMD_STOP: run_clr = 1'b1;
							default: begin
								mem_we           = 1'b1;
								mem_wdata.count  = count_q;
								mem_wdata.reload = count_q;
								run_clr          = 1'b1;
							end
						endcase
					end else if (last) begin
						finish     = 1'b1;
						new_status = stb_pkg::STATUS_NOT_FOUND;
					end
				end
				default: finish = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= stb_pkg::ST_IDLE;
			in_use_q <= '0;
			run_q    <= '0;
			hcnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (use_set)
				in_use_q[idx_q] <= 1'b1;
			else if (use_clr)
				in_use_q[idx_q] <= 1'b0;
			if (run_set)
				run_q[idx_q] <= 1'b1;
			else if (run_clr)
				run_q[idx_q] <= 1'b0;
			if (take_handle)
				hcnt_q <= hcnt_q + 32'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q      <= cmd;
			handle_q   <= handle;
			periodic_q <= periodic;
			idx_q      <= '0;
			status_q   <= stb_pkg::STATUS_OK;
			nh_q       <= '0;
			fired_q    <= 1'b0;
			fh_q       <= '0;
		end else begin
			if (state_q == stb_pkg::ST_DIV && div_rsp.done)
				count_q <= div_rsp.quo;
			if (state_q == stb_pkg::ST_EVAL) begin
				if (finish)
					status_q <= new_status;
				else
					idx_q <= idx_q + IW'(1);
			end
			if (fire) begin
				fired_q <= 1'b1;
				fh_q    <= rd_q.handle;
			end
			if (take_handle)
				nh_q <= nh_next;
		end
	end

	// slot memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[idx_q] <= mem_wdata;
		rd_q <= mem[idx_q];
	end

	`STB_ASSERT_IMP(a_div_done_in_div, div_rsp.done, state_q == stb_pkg::ST_DIV, "divider result outside divide state")
	`STB_ASSERT_IMP(a_full_means_all_used, (state_q == stb_pkg::ST_DONE) && (status_q == stb_pkg::STATUS_FULL), &in_use_q, "full status with a free slot")
	`STB_ASSERT_IMP(a_fire_on_tick, (state_q == stb_pkg::ST_DONE) && fired_q, cmd_q == stb_pkg::CMD_TICK, "fired on a non-tick command")
	`STB_ASSERT_NXT(a_take_to_idle, (state_q == stb_pkg::ST_DONE) && res_take, state_q == stb_pkg::ST_IDLE, "sequencer did not return to idle")

endmodule

@@ design/software_timer_bank.sv @@
// bank of SLOTS software timers addressed by handle
// input channel: in_valid/in_stall carries cmd, handle, delay_us, periodic; a
// transaction happens when in_valid is high and in_stall is low
// output channel: out_valid/out_stall carries status, new_handle, fired,
// fired_handle; exactly one result per input transaction, in order
// config channel: cfg_valid/cfg_ready writes timebase_us (values below 10 read
// as 10); cfg_ready is always high, write only while the bank is idle
// operation: the sequencer walks the slot memory one slot at a time, reading a slot
// (ST_RD) and then evaluating it (ST_EVAL); a tick visits every slot; handle commands
// stop at the matching slot; register and set_time first run a serial divider, one
// quotient bit per cycle
// one item is worked at a time: in_stall is high from acceptance until its
// result moves into the output register
// the output register holds a result while out_stall is high, and the next
// item may be accepted meanwhile; its result waits until the register frees
// reset clears all slot valid and running bits, the handle counter and the
// output valid, and sets timebase_us to 1000
module software_timer_bank #(
	parameter int SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  cmd,
	input  logic [31:0] handle,
	input  logic [31:0] delay_us,
	input  logic        periodic,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] new_handle,
	output logic        fired,
	output logic [31:0] fired_handle,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	localparam logic [31:0] TIMEBASE_MIN = 32'd10;
	localparam logic [31:0] TIMEBASE_RST = 32'd1000;

	logic [31:0]       timebase_q;
	logic              out_valid_q;
	logic              res_take;
	stb_pkg::result_t  res;
	stb_pkg::div_req_t div_req;
	stb_pkg::div_rsp_t div_rsp;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			timebase_q <= TIMEBASE_RST;
		else if (cfg_valid && cfg_ready)
			timebase_q <= (cfg_data < TIMEBASE_MIN) ? TIMEBASE_MIN : cfg_data;
	end

	stb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	stb_seq #(
		.SLOTS (SLOTS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.handle   (handle),
		.delay_us (delay_us),
		.periodic (periodic),
		.timebase (timebase_q),
		.res      (res),
		.res_take (res_take),
		.div_req  (div_req),
		.div_rsp  (div_rsp)
	);

	assign res_take = res.valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (res_take)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			status       <= res.status;
			new_handle   <= res.new_handle;
			fired        <= res.fired;
			fired_handle <= res.fired_handle;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

	localparam logic [2:0]  CMD_UNUSED    = 3'd7;
	localparam logic [31:0] HANDLE_BASE   = 32'hEEDF;
	localparam logic [31:0] MIN_TICK_US   = 32'd10;
	localparam logic [31:0] RESET_TICK_US = 32'd1000;
	localparam logic [31:0] COUNT_FLOOR   = 32'h8000_0000;
	localparam int BANK_SLOTS  = 16;
	localparam int IDLE_LIMIT  = 4000;
	localparam int PHASE_ITEMS = 125;
	localparam int PHASES      = 6;
	localparam int FILL_ITEMS  = 18;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_TAIL  = 100;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] new_handle;
		logic        fired;
		logic [31:0] fired_handle;
	} timer_result_t;

	typedef struct packed {
		logic [2:0]    cmd;
		logic [31:0]   handle;
		logic [31:0]   delay_us;
		logic          periodic;
		logic          typed;
		timer_result_t want;
	} timer_cmd_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  cmd;
	logic [31:0] handle;
	logic [31:0] delay_us;
	logic        periodic;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [31:0] new_handle;
	logic        fired;
	logic [31:0] fired_handle;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;

	software_timer_bank #(
		.SLOTS(BANK_SLOTS)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.handle      (handle),
		.delay_us    (delay_us),
		.periodic    (periodic),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.new_handle  (new_handle),
		.fired       (fired),
		.fired_handle(fired_handle),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	// timer bank mirror
	logic        bank_in_use   [BANK_SLOTS];
	logic [31:0] bank_handle   [BANK_SLOTS];
	logic [31:0] bank_count    [BANK_SLOTS];
	logic [31:0] bank_reload   [BANK_SLOTS];
	logic        bank_periodic [BANK_SLOTS];
	logic        bank_running  [BANK_SLOTS];
	logic [31:0] handle_serial;
	logic [31:0] tick_period;

	timer_cmd_t    timer_cmds[$];
	timer_result_t pending_results[$];

	int mismatches;
	int result_seq;
	int send_idle_pct;
	int recv_idle_pct;
	int random_left;
	int fill_left;
	int hold_req;
	bit send_pause;
	bit in_busy;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR: %s", msg);
		mismatches++;
	endtask

	function automatic logic [31:0] delay_to_ticks(input logic [31:0] delay);
		logic [63:0] tb64;
		logic [63:0] d64;
		logic [63:0] q64;
		tb64 = {32'd0, tick_period};
		d64 = (delay < tick_period) ? tb64 : {32'd0, delay};
		// rounds half up
		q64 = (64'd2 * d64 + tb64) / (64'd2 * tb64);
		return q64[31:0];
	endfunction

	function automatic timer_result_t predict_timer(input timer_cmd_t c);
		timer_result_t r;
		int s;
		r = '0;
		s = -1;
		unique case (c.cmd)
			stb_pkg::CMD_TICK: begin
				for (int i = 0; i < BANK_SLOTS; i++) begin
					if (bank_in_use[i] && bank_running[i]) begin
						if (bank_count[i] != COUNT_FLOOR)
							bank_count[i] = bank_count[i] - 32'd1;
						// only the lowest expired slot fires
						if (!r.fired && (bank_count[i] == 32'd0 || bank_count[i][31])) begin
							r.fired = 1'b1;
							r.fired_handle = bank_handle[i];
							if (bank_periodic[i])
								bank_count[i] = bank_reload[i];
							else
								bank_running[i] = 1'b0;
						end
					end
				end
			end
			stb_pkg::CMD_REGISTER: begin
				for (int i = 0; i < BANK_SLOTS; i++)
					if (s < 0 && !bank_in_use[i])
						s = i;
				if (s < 0) begin
					r.status = stb_pkg::STATUS_FULL;
				end else begin
					handle_serial = handle_serial + 32'd1;
					r.new_handle = HANDLE_BASE + handle_serial;
					bank_in_use[s] = 1'b1;
					bank_handle[s] = r.new_handle;
					bank_reload[s] = delay_to_ticks(c.delay_us);
					bank_count[s] = bank_reload[s];
					bank_periodic[s] = c.periodic;
					bank_running[s] = 1'b0;
				end
			end
			stb_pkg::CMD_UNREGISTER, stb_pkg::CMD_START, stb_pkg::CMD_STOP,
			stb_pkg::CMD_SET_TIME, stb_pkg::CMD_RESTART: begin
				for (int i = 0; i < BANK_SLOTS; i++)
					if (s < 0 && bank_in_use[i] && bank_handle[i] == c.handle)
						s = i;
				if (s < 0) begin
					r.status = stb_pkg::STATUS_NOT_FOUND;
				end else begin
					unique case (c.cmd)
						stb_pkg::CMD_UNREGISTER: begin
							bank_in_use[s] = 1'b0;
							bank_handle[s] = '0;
							bank_count[s] = '0;
							bank_reload[s] = '0;
							bank_periodic[s] = 1'b0;
							bank_running[s] = 1'b0;
						end
						stb_pkg::CMD_STOP: begin
							bank_running[s] = 1'b0;
						end
						stb_pkg::CMD_SET_TIME: begin
							bank_running[s] = 1'b0;
							bank_reload[s] = delay_to_ticks(c.delay_us);
							bank_count[s] = bank_reload[s];
						end
						default: begin
							bank_count[s] = bank_reload[s];
							bank_running[s] = 1'b1;
						end
					endcase
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic timer_cmd_t make_random_item();
		timer_cmd_t c;
		int pick;
		int live;
		int k;
		logic [63:0] d64;
		c = '0;
		c.handle = $urandom;
		c.delay_us = $urandom;
		c.periodic = $urandom_range(0, 1);
		if (fill_left > 0) begin
			fill_left--;
			c.cmd = stb_pkg::CMD_REGISTER;
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 34)
				c.cmd = stb_pkg::CMD_TICK;
			else if (pick < 48)
				c.cmd = stb_pkg::CMD_REGISTER;
			else if (pick < 60)
				c.cmd = stb_pkg::CMD_START;
			else if (pick < 68)
				c.cmd = stb_pkg::CMD_RESTART;
			else if (pick < 75)
				c.cmd = stb_pkg::CMD_STOP;
			else if (pick < 83)
				c.cmd = stb_pkg::CMD_SET_TIME;
			else if (pick < 95)
				c.cmd = stb_pkg::CMD_UNREGISTER;
			else
				c.cmd = CMD_UNUSED;
		end
		live = 0;
		for (int i = 0; i < BANK_SLOTS; i++)
			if (bank_in_use[i])
				live++;
		if (live > 0 && $urandom_range(0, 99) < 85) begin
			k = $urandom_range(0, live - 1);
			for (int i = 0; i < BANK_SLOTS; i++) begin
				if (bank_in_use[i]) begin
					if (k == 0)
						c.handle = bank_handle[i];
					k--;
				end
			end
		end else if ($urandom_range(0, 1) == 1) begin
			// stale or not yet issued handles
			c.handle = HANDLE_BASE + $urandom_range(0, handle_serial + 32'd2);
		end
		// keep most delays within a few ticks so timers actually expire
		if ($urandom_range(0, 3) != 0) begin
			d64 = {32'd0, tick_period} * $urandom_range(0, 4) + $urandom_range(0, tick_period);
			c.delay_us = (d64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : d64[31:0];
		end
		return c;
	endfunction

	function automatic void add_row(input logic [2:0] c, input logic [31:0] h,
			input logic [31:0] d, input logic p, input logic typed,
			input logic [1:0] st, input logic [31:0] nh, input logic f,
			input logic [31:0] fh);
		timer_cmd_t row;
		row.cmd = c;
		row.handle = h;
		row.delay_us = d;
		row.periodic = p;
		row.typed = typed;
		row.want.status = st;
		row.want.new_handle = nh;
		row.want.fired = f;
		row.want.fired_handle = fh;
		timer_cmds.push_back(row);
	endfunction

	task automatic write_timebase(input logic [31:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		tick_period = (value < MIN_TICK_US) ? MIN_TICK_US : value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		@(posedge clk);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
	endtask

	task automatic wait_drained();
		while (timer_cmds.size() > 0 || random_left > 0 || in_busy || pending_results.size() > 0)
			@(posedge clk);
	endtask

	// input side: in_valid is assigned on a falling edge and held while in_stall is high
	initial begin : cmd_driver
		timer_cmd_t cur;
		timer_result_t exp_r;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (!send_pause && (timer_cmds.size() > 0 || random_left > 0)
					&& $urandom_range(0, 99) >= send_idle_pct) begin
				if (timer_cmds.size() > 0) begin
					cur = timer_cmds.pop_front();
				end else begin
					cur = make_random_item();
					random_left--;
				end
				in_busy = 1'b1;
				in_valid <= 1'b1;
				cmd <= cur.cmd;
				handle <= cur.handle;
				delay_us <= cur.delay_us;
				periodic <= cur.periodic;
				do @(posedge clk); while (in_stall);
				exp_r = predict_timer(cur);
				if (cur.typed)
					exp_r = cur.want;
				pending_results.push_back(exp_r);
				in_busy = 1'b0;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	initial begin : result_receiver
		int hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin : result_check
		timer_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with no transaction pending",
					result_seq));
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status)
					report_mismatch($sformatf("result %0d status %0d expected %0d",
						result_seq, status, want.status));
				if (new_handle !== want.new_handle)
					report_mismatch($sformatf("result %0d new_handle %h expected %h",
						result_seq, new_handle, want.new_handle));
				if (fired !== want.fired)
					report_mismatch($sformatf("result %0d fired %b expected %b",
						result_seq, fired, want.fired));
				if (fired_handle !== want.fired_handle)
					report_mismatch($sformatf("result %0d fired_handle %h expected %h",
						result_seq, fired_handle, want.fired_handle));
			end
			result_seq++;
		end
	end

	// ends the run when no channel moves a transaction for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin : main_seq
		logic [31:0] phase_tb [PHASES];
		logic [31:0] tb_value;
		in_valid = 1'b0;
		cmd = stb_pkg::CMD_TICK;
		handle = '0;
		delay_us = '0;
		periodic = 1'b0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		arst_n = 1'b0;
		mismatches = 0;
		result_seq = 0;
		random_left = 0;
		fill_left = 0;
		hold_req = 0;
		send_pause = 1'b0;
		in_busy = 1'b0;
		send_idle_pct = 8;
		recv_idle_pct = 66;
		tick_period = RESET_TICK_US;
		handle_serial = '0;
		for (int i = 0; i < BANK_SLOTS; i++) begin
			bank_in_use[i] = 1'b0;
			bank_handle[i] = '0;
			bank_count[i] = '0;
			bank_reload[i] = '0;
			bank_periodic[i] = 1'b0;
			bank_running[i] = 1'b0;
		end
		phase_tb[0] = 32'd0;
		phase_tb[1] = 32'hFFFF_FFFF;
		phase_tb[2] = MIN_TICK_US;
		phase_tb[3] = 32'd9;
		phase_tb[4] = RESET_TICK_US;
		phase_tb[5] = RESET_TICK_US;

		// idle tick, unused command and unknown handle straight after reset
		add_row(stb_pkg::CMD_TICK, '0, '0, 1'b0, 1'b1,
			stb_pkg::STATUS_OK, '0, 1'b0, '0);
		add_row(CMD_UNUSED, '1, '1, 1'b1, 1'b1,
			stb_pkg::STATUS_OK, '0, 1'b0, '0);
		add_row(stb_pkg::CMD_UNREGISTER, '0, '0, 1'b0, 1'b1,
			stb_pkg::STATUS_NOT_FOUND, '0, 1'b0, '0);
		add_row(stb_pkg::CMD_REGISTER, '0, '0, 1'b0, 1'b1,
			stb_pkg::STATUS_OK, HANDLE_BASE + 32'd1, 1'b0, '0);
		add_row(stb_pkg::CMD_REGISTER, '1, '1, 1'b1, 1'b1,
			stb_pkg::STATUS_OK, HANDLE_BASE + 32'd2, 1'b0, '0);
		add_row(stb_pkg::CMD_START, HANDLE_BASE + 32'd1, '0, 1'b0, 1'b1,
			stb_pkg::STATUS_OK, '0, 1'b0, '0);
		add_row(stb_pkg::CMD_TICK, '0, '0, 1'b0, 1'b1,
			stb_pkg::STATUS_OK, '0, 1'b1, HANDLE_BASE + 32'd1);
		add_row(stb_pkg::CMD_TICK, '0, '0, 1'b0, 1'b1,
			stb_pkg::STATUS_OK, '0, 1'b0, '0);
		add_row(stb_pkg::CMD_RESTART, HANDLE_BASE + 32'd1, '0, 1'b0, 1'b0, '0, '0, 1'b0, '0);
		// rounding exactly at and just below the half tick
		add_row(stb_pkg::CMD_REGISTER, '0, 32'd1500, 1'b1, 1'b0, '0, '0, 1'b0, '0);
		add_row(stb_pkg::CMD_REGISTER, '0, 32'd1499, 1'b0, 1'b0, '0, '0, 1'b0, '0);
		add_row(stb_pkg::CMD_START, HANDLE_BASE + 32'd3, '0, 1'b0, 1'b0, '0, '0, 1'b0, '0);
		add_row(stb_pkg::CMD_START, HANDLE_BASE + 32'd4, '0, 1'b0, 1'b0, '0, '0, 1'b0, '0);
		// two slots expire together, the higher one waits
		add_row(stb_pkg::CMD_TICK, '0, '0, 1'b0, 1'b0, '0, '0, 1'b0, '0);
		add_row(stb_pkg::CMD_TICK, '0, '0, 1'b0, 1'b0, '0, '0, 1'b0, '0);
		add_row(stb_pkg::CMD_TICK, '0, '0, 1'b0, 1'b0, '0, '0, 1'b0, '0);
		add_row(stb_pkg::CMD_SET_TIME, HANDLE_BASE + 32'd3, 32'd2500, 1'b0, 1'b0,
			'0, '0, 1'b0, '0);
		add_row(stb_pkg::CMD_STOP, HANDLE_BASE + 32'd2, '0, 1'b0, 1'b0, '0, '0, 1'b0, '0);
		add_row(stb_pkg::CMD_STOP, '1, '0, 1'b0, 1'b1,
			stb_pkg::STATUS_NOT_FOUND, '0, 1'b0, '0);
		add_row(stb_pkg::CMD_UNREGISTER, HANDLE_BASE + 32'd2, '0, 1'b0, 1'b0,
			'0, '0, 1'b0, '0);
		add_row(stb_pkg::CMD_START, HANDLE_BASE + 32'd2, '0, 1'b0, 1'b1,
			stb_pkg::STATUS_NOT_FOUND, '0, 1'b0, '0);
		add_row(stb_pkg::CMD_SET_TIME, HANDLE_BASE + 32'd4, '0, 1'b0, 1'b0,
			'0, '0, 1'b0, '0);
		add_row(stb_pkg::CMD_RESTART, 32'h1234_5678, '0, 1'b0, 1'b1,
			stb_pkg::STATUS_NOT_FOUND, '0, 1'b0, '0);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		wait_drained();

		for (int phase = 0; phase < PHASES; phase++) begin
			tb_value = (phase == PHASES - 1) ? $urandom_range(11, 5000) : phase_tb[phase];
			write_timebase(tb_value);
			if (phase < 2)
				set_idling(8, 66);
			else if (phase < 4)
				set_idling(66, 8);
			else
				set_idling(0, 0);
			// a burst of registers first so the bank runs full
			fill_left = FILL_ITEMS;
			random_left = PHASE_ITEMS;
			if (phase == 4) begin
				while (random_left > PHASE_ITEMS - 20)
					@(posedge clk);
				hold_req = HOLD_CYCLES;
				while (random_left > PHASE_ITEMS - 60)
					@(posedge clk);
				send_pause = 1'b1;
				while (in_busy || pending_results.size() > 0)
					@(posedge clk);
				send_pause = 1'b0;
			end
			wait_drained();
		end

		repeat (DRAIN_TAIL) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
